@@ hdl/tsau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsau_pkg
// Types and codes shared by the Thumb-2 store address unit.
// ----------------------------------------------------------------------------
package tsau_pkg;

    localparam logic [1:0] OP_STRB     = 2'd0;
    localparam logic [1:0] OP_STRH_IMM = 2'd1;
    localparam logic [1:0] OP_STRH_REG = 2'd2;
    localparam logic [1:0] OP_STRD_IMM = 2'd3;

    localparam logic [1:0] KIND_STORE     = 2'd0;
    localparam logic [1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [1:0] KIND_ERROR     = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // STRB encodings, tested on instruction bits 31:20 (and bit 11 for imm8)
    localparam logic [11:0] STRB_IMM12_OPC = 12'hF88;
    localparam logic [11:0] STRB_IMM8_OPC  = 12'hF80;

    localparam int unsigned PLAN_DEPTH = 3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] instruction;
        logic [31:0] base_value;
        logic [31:0] index_value;
        logic [31:0] store_value;
        logic [31:0] store_value_second;
        logic [31:0] pc_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] data;
        logic [3:0]  write_register;
        logic [31:0] next_pc;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] data;
        logic [3:0]  write_register;
    } entry_t;

    // Decoded instruction: up to three transfers plus the PC for the final one
    typedef struct packed {
        entry_t [PLAN_DEPTH-1:0] entry;
        logic [1:0]              last_idx;
        logic [31:0]             next_pc;
    } plan_t;

endpackage

@@ hdl/thumb2_store_address_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb2_store_address_unit
// Executes Thumb-2 STRB, STRH and STRD stores: address generation, store
// transfers, base write-back and next PC.
// ----------------------------------------------------------------------------
//  channel   valid          stall          payload
//  input     item_valid     item_stall     item   (tsau_pkg::item_t)
//  output    result_valid   result_stall   result (tsau_pkg::result_t)
//
// Input register, decode, transfer buffer, result register.
// An instruction passes the input register and transfer buffer, and each of its
// results the result register. One result per cycle while result_stall is low;
// an instruction holds the buffer for its 1 to 3 results (STRD with write-back: 3).
// Reset clears all valid flags; result_stall holds the result register and
// backs up through the buffer to item_stall.
// ----------------------------------------------------------------------------
module thumb2_store_address_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tsau_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output tsau_pkg::result_t result
);

    logic            in_v_reg;
    logic            in_v_next;
    tsau_pkg::item_t in_reg;
    tsau_pkg::plan_t plan;
    logic            plan_ready;
    logic            in_take;
    logic [1:0]      idx;
    logic [1:0]      last_idx;
    logic            busy;

    assign item_stall = in_v_reg && !plan_ready;
    assign in_take    = item_valid && !item_stall;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (in_take)
        begin
            in_v_next = 1'b1;
        end
        else if (plan_ready)
        begin
            in_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= in_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= item;
        end
    end

    tsau_decode u_decode
    (
        .item (in_reg),
        .plan (plan)
    );

    tsau_issue u_issue
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .plan_valid   (in_v_reg),
        .plan         (plan),
        .plan_ready   (plan_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .idx          (idx),
        .last_idx     (last_idx),
        .busy         (busy)
    );

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (idx <= last_idx))
        else $error("transfer index beyond last transfer");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == tsau_pkg::KIND_ERROR) |-> result.last)
        else $error("error result not marked last");

    a_pc_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (result.next_pc == 32'd0))
        else $error("next PC on a non-final transfer");

    a_wb_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == tsau_pkg::KIND_WRITEBACK) |-> result.last)
        else $error("write-back not the final transfer");

endmodule

@@ hdl/tsau_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsau_decode
// Decodes one store instruction and forms its addresses and transfers.
// ----------------------------------------------------------------------------
module tsau_decode
(
    input  tsau_pkg::item_t item,
    output tsau_pkg::plan_t plan
);

    logic        strb_imm12;
    logic        strb_imm8;
    logic        up;
    logic        pre;
    logic        wb;
    logic [31:0] addend;
    logic [31:0] offs;
    logic [31:0] addr;
    logic [31:0] addr_hi;
    logic [3:0]  rn_idx;
    logic [31:0] insn;
    logic [31:0] rn_val;

    assign insn   = item.instruction;
    assign rn_val = item.base_value;
    assign rn_idx = insn[19:16];

    assign strb_imm12 = (insn[31:20] == tsau_pkg::STRB_IMM12_OPC);
    assign strb_imm8  = (insn[31:20] == tsau_pkg::STRB_IMM8_OPC) && insn[11];

    always_comb
    begin
        addend = {20'd0, insn[11:0]};
        up     = 1'b1;
        pre    = 1'b1;
        wb     = 1'b0;
        case (item.operation)
            tsau_pkg::OP_STRB:
            begin
                if (!strb_imm12)
                begin
                    addend = {24'd0, insn[7:0]};
                    up     = insn[9];
                    pre    = insn[10];
                    wb     = insn[8];
                end
            end
            tsau_pkg::OP_STRH_IMM:
            begin
                addend = {20'd0, insn[11:0]};
            end
            tsau_pkg::OP_STRH_REG:
            begin
                addend = item.index_value << insn[5:4];
            end
            tsau_pkg::OP_STRD_IMM:
            begin
                addend = {22'd0, insn[7:0], 2'b00};
                up     = insn[23];
                pre    = insn[24];
                wb     = insn[21];
            end
            default:
            begin
                addend = {20'd0, insn[11:0]};
            end
        endcase
    end

    assign offs    = up ? rn_val + addend : rn_val - addend;
    assign addr    = pre ? offs : rn_val;
    assign addr_hi = pre ? offs + 32'd4 : rn_val + 32'd4;

    always_comb
    begin
        plan          = '0;
        plan.next_pc  = item.pc_value + 32'd4;
        plan.last_idx = 2'd0;

        plan.entry[0].kind    = tsau_pkg::KIND_STORE;
        plan.entry[0].address = addr;

        plan.entry[1].kind           = tsau_pkg::KIND_WRITEBACK;
        plan.entry[1].access_size    = tsau_pkg::SIZE_WORD;
        plan.entry[1].data           = offs;
        plan.entry[1].write_register = rn_idx;

        plan.entry[2].kind           = tsau_pkg::KIND_WRITEBACK;
        plan.entry[2].access_size    = tsau_pkg::SIZE_WORD;
        plan.entry[2].data           = offs;
        plan.entry[2].write_register = rn_idx;

        case (item.operation)
            tsau_pkg::OP_STRB:
            begin
                plan.entry[0].access_size = tsau_pkg::SIZE_BYTE;
                plan.entry[0].data        = {24'd0, item.store_value[7:0]};
                if (strb_imm8)
                begin
                    plan.last_idx = {1'b0, wb};
                end
                else if (!strb_imm12)
                begin
                    plan.entry[0] = '0;
                    plan.entry[0].kind = tsau_pkg::KIND_ERROR;
                end
            end
            tsau_pkg::OP_STRH_IMM, tsau_pkg::OP_STRH_REG:
            begin
                plan.entry[0].access_size = tsau_pkg::SIZE_HALF;
                plan.entry[0].data        = {16'd0, item.store_value[15:0]};
            end
            tsau_pkg::OP_STRD_IMM:
            begin
                plan.entry[0].access_size = tsau_pkg::SIZE_WORD;
                plan.entry[0].data        = item.store_value;
                plan.entry[1]             = '0;
                plan.entry[1].kind        = tsau_pkg::KIND_STORE;
                plan.entry[1].access_size = tsau_pkg::SIZE_WORD;
                plan.entry[1].address     = addr_hi;
                plan.entry[1].data        = item.store_value_second;
                plan.last_idx             = wb ? 2'd2 : 2'd1;
            end
            default:
            begin
                plan.last_idx = 2'd0;
            end
        endcase
    end

endmodule

@@ hdl/tsau_issue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsau_issue
// Holds one decoded instruction and issues its transfers through the
// result register, one per cycle unless result_stall holds that register.
// ----------------------------------------------------------------------------
module tsau_issue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            plan_valid,
    input  tsau_pkg::plan_t plan,
    output logic            plan_ready,
    output logic            result_valid,
    input  logic            result_stall,
    output tsau_pkg::result_t result,
    output logic [1:0]      idx,
    output logic [1:0]      last_idx,
    output logic            busy
);

    logic              plan_v_reg;
    logic              plan_v_next;
    tsau_pkg::plan_t   plan_reg;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic              out_v_reg;
    logic              out_v_next;
    tsau_pkg::result_t out_reg;
    tsau_pkg::result_t out_next;
    tsau_pkg::entry_t  cur;
    logic              out_load;
    logic              plan_done;
    logic              plan_load;
    logic              is_last;

    assign out_load   = plan_v_reg && (!out_v_reg || !result_stall);
    assign is_last    = (idx_reg == plan_reg.last_idx);
    assign plan_done  = out_load && is_last;
    assign plan_ready = !plan_v_reg || plan_done;
    assign plan_load  = plan_valid && plan_ready;

    assign cur = plan_reg.entry[idx_reg];

    always_comb
    begin
        out_next.kind           = cur.kind;
        out_next.access_size    = cur.access_size;
        out_next.address        = cur.address;
        out_next.data           = cur.data;
        out_next.write_register = cur.write_register;
        out_next.last           = is_last;
        out_next.next_pc        = is_last ? plan_reg.next_pc : 32'd0;
    end

    always_comb
    begin
        plan_v_next = plan_v_reg;
        idx_next    = idx_reg;
        if (plan_load)
        begin
            plan_v_next = 1'b1;
            idx_next    = 2'd0;
        end
        else if (plan_done)
        begin
            plan_v_next = 1'b0;
            idx_next    = 2'd0;
        end
        else if (out_load)
        begin
            idx_next = idx_reg + 2'd1;
        end
        out_v_next = out_v_reg;
        if (out_load)
        begin
            out_v_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_v_reg <= 1'b0;
            idx_reg    <= 2'd0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            plan_v_reg <= plan_v_next;
            idx_reg    <= idx_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (plan_load)
        begin
            plan_reg <= plan;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;
    assign idx          = idx_reg;
    assign last_idx     = plan_reg.last_idx;
    assign busy         = plan_v_reg;

endmodule
